// ===== hdl/s5uhs_pkg.sv =====
// Shared types and constants for the SOCKS5 UDP header stripper.
// Used by the parser, the result queue and the top level; no dependencies.
package s5uhs_pkg;

  // Width of the saturating byte counter.
  localparam int POS_BITS = 16;
  // Width used for position compares, wider than the byte counter.
  localparam int CMP_W = 33;

  // Address type codes on the wire.
  localparam logic [7:0] ATYP_IPV4 = 8'h01;
  localparam logic [7:0] ATYP_NAME = 8'h03;
  localparam logic [7:0] ATYP_IPV6 = 8'h04;

  // Fixed header lengths.
  localparam int IPV4_HDR_LEN = 10;
  localparam int NAME_HDR_BASE = 7;
  localparam int NAME_TEXT_BASE = 4;

  // Text characters.
  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_NINE = 8'h39;
  localparam logic [7:0] CHR_DOT = 8'h2E;
  localparam logic [7:0] CHR_NUL = 8'h00;

  // Octets in a dotted quad.
  localparam logic [2:0] QUAD_OCTETS = 3'd4;

  // Result word kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Result queue geometry.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW = 2;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_SHORT = 3'd1,
    ERR_RSV   = 3'd2,
    ERR_FRAG  = 3'd3,
    ERR_ATYP  = 3'd4,
    ERR_NAME  = 3'd5
  } err_t;

  // One queue entry: an optional payload word, then an optional status word.
  typedef struct packed {
    logic        has_pay;
    logic [7:0]  pay;
    logic        has_stat;
    err_t        err;
    logic [31:0] addr;
    logic [15:0] port;
    logic [15:0] len;
  } rec_t;

endpackage

// ===== hdl/s5uhs_parse.sv =====
// Header parser: per-byte parse state and the result record for each word.
// Depends on s5uhs_pkg.
module s5uhs_parse import s5uhs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       push,
  output rec_t       rec
);

  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [7:0]          atyp_r, atyp_nxt;
  logic [7:0]          nlen_r, nlen_nxt;
  logic [31:0]         addr_r, addr_nxt;
  logic [15:0]         port_r, port_nxt;
  err_t                fault_r, fault_nxt;
  logic [8:0]          ov_r, ov_nxt;
  logic [2:0]          oc_r, oc_nxt;
  logic                dseen_r, dseen_nxt;
  logic                tend_r, tend_nxt;
  logic                tinv_r, tinv_nxt;

  logic [CMP_W-1:0]    idx;
  logic [CMP_W-1:0]    text_last;
  logic [CMP_W-1:0]    hdr;
  logic [CMP_W-1:0]    cnt_x;
  logic [CMP_W-1:0]    plen;
  logic [POS_BITS-1:0] cnt;
  logic [12:0]         grown;
  logic                known;
  logic                emit_pay;
  err_t                err;

  // Parse one byte and build its result record
  always_comb begin
    pos_nxt   = pos_r;
    atyp_nxt  = atyp_r;
    nlen_nxt  = nlen_r;
    addr_nxt  = addr_r;
    port_nxt  = port_r;
    fault_nxt = fault_r;
    ov_nxt    = ov_r;
    oc_nxt    = oc_r;
    dseen_nxt = dseen_r;
    tend_nxt  = tend_r;
    tinv_nxt  = tinv_r;

    idx   = CMP_W'(pos_r);
    grown = 13'({ov_r, 3'b000}) + 13'({ov_r, 1'b0}) + 13'(data_byte - CHR_ZERO);

    // Record the first reserved or fragment fault
    if (idx < CMP_W'(3) && data_byte != 8'h00 && fault_r == ERR_OK) begin
      fault_nxt = (idx < CMP_W'(2)) ? ERR_RSV : ERR_FRAG;
    end

    // Capture address type and name length
    if (idx == CMP_W'(3)) begin
      atyp_nxt = data_byte;
    end else if (idx == CMP_W'(4) && atyp_r == ATYP_NAME) begin
      nlen_nxt = data_byte;
    end

    text_last = CMP_W'(nlen_nxt) + CMP_W'(NAME_TEXT_BASE);

    // Accumulate address and port fields
    if (atyp_nxt == ATYP_IPV4 && idx >= CMP_W'(4)) begin
      if (idx <= CMP_W'(7)) begin
        addr_nxt = {addr_r[23:0], data_byte};
      end else if (idx <= CMP_W'(9)) begin
        port_nxt = {port_r[7:0], data_byte};
      end
    end else if (atyp_nxt == ATYP_NAME && idx >= CMP_W'(5)) begin
      if (idx <= text_last) begin
        // Check the dotted-quad text one character at a time
        if (!tend_r && !tinv_r) begin
          if (data_byte == CHR_NUL) begin
            tend_nxt = 1'b1;
          end else if (data_byte >= CHR_ZERO && data_byte <= CHR_NINE) begin
            if (dseen_r && ov_r == 9'd0) begin
              tinv_nxt = 1'b1;          // leading zero
            end else if (grown > 13'd255) begin
              tinv_nxt = 1'b1;          // octet out of range
            end else begin
              ov_nxt   = grown[8:0];
              addr_nxt = {addr_r[31:8], grown[7:0]};
              if (!dseen_r) begin
                if (oc_r >= QUAD_OCTETS) begin
                  tinv_nxt = 1'b1;
                end else begin
                  oc_nxt    = oc_r + 3'd1;
                  dseen_nxt = 1'b1;
                end
              end
            end
          end else if (data_byte == CHR_DOT && dseen_r) begin
            if (oc_r == QUAD_OCTETS) begin
              tinv_nxt = 1'b1;
            end else begin
              addr_nxt  = {addr_r[23:0], 8'h00};
              ov_nxt    = 9'd0;
              dseen_nxt = 1'b0;
            end
          end else begin
            tinv_nxt = 1'b1;
          end
        end
        if (idx == text_last) begin
          tend_nxt = 1'b1;
        end
      end else if (idx <= text_last + CMP_W'(2)) begin
        port_nxt = {port_r[7:0], data_byte};
      end
    end

    // Header length for the known address types
    known = (atyp_nxt == ATYP_IPV4) || (atyp_nxt == ATYP_NAME);
    if (atyp_nxt == ATYP_IPV4) begin
      hdr = CMP_W'(IPV4_HDR_LEN);
    end else if (atyp_nxt == ATYP_NAME) begin
      hdr = CMP_W'(nlen_nxt) + CMP_W'(NAME_HDR_BASE);
    end else begin
      hdr = '0;
    end
    emit_pay = known && (idx >= hdr);

    // Advance the saturating byte count
    cnt     = (pos_r == '1) ? pos_r : pos_r + POS_BITS'(1);
    pos_nxt = cnt;
    cnt_x   = CMP_W'(cnt);

    // Pick the error code in priority order
    priority if (cnt_x < CMP_W'(IPV4_HDR_LEN)) begin
      err = ERR_SHORT;
    end else if (fault_nxt != ERR_OK) begin
      err = fault_nxt;
    end else if (!known) begin
      err = ERR_ATYP;
    end else if (atyp_nxt == ATYP_NAME && cnt_x < hdr) begin
      err = ERR_SHORT;
    end else if (atyp_nxt == ATYP_NAME && (tinv_nxt || oc_nxt != QUAD_OCTETS)) begin
      err = ERR_NAME;
    end else begin
      err = ERR_OK;
    end

    plen = cnt_x - hdr;

    rec.has_pay  = emit_pay;
    rec.pay      = data_byte;
    rec.has_stat = last_byte;
    rec.err      = err;
    if (err == ERR_OK) begin
      rec.addr = addr_nxt;
      rec.port = port_nxt;
      rec.len  = (plen > CMP_W'(16'hFFFF)) ? 16'hFFFF : plen[15:0];
    end else begin
      rec.addr = '0;
      rec.port = '0;
      rec.len  = '0;
    end

    push = accept && (emit_pay || last_byte);

    // Drop all parse state after the last byte
    if (last_byte) begin
      pos_nxt   = '0;
      atyp_nxt  = '0;
      nlen_nxt  = '0;
      addr_nxt  = '0;
      port_nxt  = '0;
      fault_nxt = ERR_OK;
      ov_nxt    = '0;
      oc_nxt    = '0;
      dseen_nxt = 1'b0;
      tend_nxt  = 1'b0;
      tinv_nxt  = 1'b0;
    end
  end

  // Hold parse state; advance on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      atyp_r  <= '0;
      nlen_r  <= '0;
      addr_r  <= '0;
      port_r  <= '0;
      fault_r <= ERR_OK;
      ov_r    <= '0;
      oc_r    <= '0;
      dseen_r <= 1'b0;
      tend_r  <= 1'b0;
      tinv_r  <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      atyp_r  <= atyp_nxt;
      nlen_r  <= nlen_nxt;
      addr_r  <= addr_nxt;
      port_r  <= port_nxt;
      fault_r <= fault_nxt;
      ov_r    <= ov_nxt;
      oc_r    <= oc_nxt;
      dseen_r <= dseen_nxt;
      tend_r  <= tend_nxt;
      tinv_r  <= tinv_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_byte |=> pos_r == '0 && atyp_r == 8'h00 && fault_r == ERR_OK)
    else $error("parse state not cleared after last word");

  a_octet_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oc_r <= QUAD_OCTETS)
    else $error("octet count beyond four");

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> accept)
    else $error("result pushed without an accepted word");
`endif

endmodule

// ===== hdl/s5uhs_outq.sv =====
// Result queue: holds parse records and emits payload then status words.
// Depends on s5uhs_pkg.
module s5uhs_outq import s5uhs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  rec_t        rec,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_item_kind,
  output logic [7:0]  out_payload_byte,
  output logic [2:0]  out_error_code,
  output logic [31:0] out_source_address,
  output logic [15:0] out_source_port,
  output logic [15:0] out_payload_length
);

  rec_t             mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] head_r, head_nxt;
  logic [OQ_AW-1:0] tail_r, tail_nxt;
  logic [OQ_AW:0]   cnt_r, cnt_nxt;
  logic             phase_r, phase_nxt;

  rec_t             head;
  logic             send_stat;
  logic             fire;
  logic             pop;

  // Select the word at the head entry
  always_comb begin
    head      = mem_r[head_r];
    send_stat = phase_r || !head.has_pay;
    out_valid = (cnt_r != '0);
    full      = (cnt_r == (OQ_AW + 1)'(OQ_DEPTH));
    fire      = out_valid && !out_stall;
    pop       = fire && (send_stat || !head.has_stat);

    out_item_kind      = send_stat ? KIND_STATUS : KIND_PAYLOAD;
    out_payload_byte   = send_stat ? 8'h00 : head.pay;
    out_error_code     = send_stat ? head.err : ERR_OK;
    out_source_address = send_stat ? head.addr : 32'h0;
    out_source_port    = send_stat ? head.port : 16'h0;
    out_payload_length = send_stat ? head.len : 16'h0;
  end

  // Advance pointers, fill count and word phase
  always_comb begin
    head_nxt  = pop ? head_r + OQ_AW'(1) : head_r;
    tail_nxt  = push ? tail_r + OQ_AW'(1) : tail_r;
    cnt_nxt   = cnt_r + (OQ_AW + 1)'(push) - (OQ_AW + 1)'(pop);
    phase_nxt = fire ? !pop : phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Write the new record at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= rec;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (OQ_AW + 1)'(OQ_DEPTH))
    else $error("result queue count overflow");

  a_phase_two_part: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> out_valid && head.has_pay && head.has_stat)
    else $error("status phase on an entry without two parts");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full result queue");
`endif

endmodule

// ===== hdl/socks5_udp_header_strip.sv =====
// SOCKS5 UDP header stripper: top level.
// Depends on s5uhs_pkg, s5uhs_parse and s5uhs_outq.
//
// Usage:
//   The input channel carries one datagram byte per word with a last marker.
//   The block checks the reserved, fragment and address type bytes, decodes
//   an IPv4 or dotted-quad domain address and the big-endian port, and
//   forwards every byte past the header as a payload word (item_kind 0).
//   After the last byte it emits one status word (item_kind 1) with the
//   error code, source address, source port and payload length; when the
//   last byte is itself payload, its payload word goes out first.
//   Each result word is registered in the result queue before it is offered.
//   Throughput: one input word per cycle while in_stall is low; the output
//   drains one word per cycle while out_stall is low, and a four-entry result
//   queue absorbs the extra status word. in_stall rises only when that queue
//   is full, i.e. when out_stall has held results back.
//   Reset clears the parse state and empties the queue; the next byte is
//   taken as the first byte of a datagram.
module socks5_udp_header_strip import s5uhs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_item_kind,
  output logic [7:0]  out_payload_byte,
  output logic [2:0]  out_error_code,
  output logic [31:0] out_source_address,
  output logic [15:0] out_source_port,
  output logic [15:0] out_payload_length
);

  logic accept;
  logic push;
  logic full;
  rec_t rec;

  // Take a word whenever the queue has room
  assign in_stall = full;
  assign accept   = in_valid && !full;

  s5uhs_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .push      (push),
    .rec       (rec)
  );

  s5uhs_outq u_outq (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .rec                (rec),
    .full               (full),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item_kind      (out_item_kind),
    .out_payload_byte   (out_payload_byte),
    .out_error_code     (out_error_code),
    .out_source_address (out_source_address),
    .out_source_port    (out_source_port),
    .out_payload_length (out_payload_length)
  );

endmodule
